FILE: hdl/assert_macros.svh
// Assertion macros of the navigation history RTL, used by the sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define BNH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define BNH_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: hdl/bnh_pkg.sv
// Package with the constants and request codes of the navigation history.
package bnh_pkg;

    localparam int BNH_DEPTH    = 16;
    localparam int BNH_ID_WIDTH = 32;

    // Width of entry counts, the cursor and the limit register.
    localparam int CNT_W = 5;
    localparam int REQ_W = 3;

    localparam logic [CNT_W-1:0] MAX_LENGTH_RESET = 5'd16;

    localparam logic [REQ_W-1:0] REQ_PUSH    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_BACK    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FORWARD = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd4;

endpackage

FILE: hdl/bnh_if.sv
// Request and response channel interfaces of the navigation history.
interface bnh_req_if
    import bnh_pkg::*;
#(
    parameter int ID_WIDTH = BNH_ID_WIDTH
) ();
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [ID_WIDTH-1:0] ident;
    logic                ident_valid;

    modport source (output valid, req_type, ident, ident_valid, input ready);
    modport sink   (input valid, req_type, ident, ident_valid, output ready);
endinterface

interface bnh_rsp_if
    import bnh_pkg::*;
#(
    parameter int ID_WIDTH = BNH_ID_WIDTH
) ();
    logic                valid;
    logic                ready;
    logic [ID_WIDTH-1:0] current_ident;
    logic                current_valid;
    logic                selection_changed;
    logic                history_updated;
    logic                back_available;
    logic                forward_available;
    logic [CNT_W-1:0]    entry_count;

    modport source (
        output valid, current_ident, current_valid, selection_changed,
               history_updated, back_available, forward_available, entry_count,
        input  ready
    );
    modport sink (
        input  valid, current_ident, current_valid, selection_changed,
               history_updated, back_available, forward_available, entry_count,
        output ready
    );
endinterface

FILE: hdl/bnh_store.sv
// Entry memory of the history: one write port and one registered read port.
module bnh_store
    import bnh_pkg::*;
#(
    parameter int DEPTH    = BNH_DEPTH,
    parameter int ID_WIDTH = BNH_ID_WIDTH,
    localparam int AW      = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output logic [ID_WIDTH-1:0] o_rd_data,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [ID_WIDTH-1:0] i_wr_data
);

    logic [ID_WIDTH-1:0] r_mem [DEPTH];
    logic [ID_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read, so a stalled result keeps it.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/bnh_ctrl.sv
// Sequencer of the history: request decode, copy/compact loop and result register.
`include "assert_macros.svh"

module bnh_ctrl
    import bnh_pkg::*;
#(
    parameter int DEPTH    = BNH_DEPTH,
    parameter int ID_WIDTH = BNH_ID_WIDTH,
    localparam int AW      = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [CNT_W-1:0]    i_max_length,
    bnh_req_if.sink             i_req,
    bnh_rsp_if.source           o_rsp,
    output logic                o_mem_rd_en,
    output logic [AW-1:0]       o_mem_rd_addr,
    input  logic [ID_WIDTH-1:0] i_mem_rd_data,
    output logic                o_mem_wr_en,
    output logic [AW-1:0]       o_mem_wr_addr,
    output logic [ID_WIDTH-1:0] o_mem_wr_data
);

    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam int CAP_INT = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;
    localparam logic [CNT_W-1:0] LIM_CAP = CNT_W'(CAP_INT);
    localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_PCHK_RD = 4'd1;
    localparam logic [3:0] S_PCHK    = 4'd2;
    localparam logic [3:0] S_CP_RD   = 4'd3;
    localparam logic [3:0] S_CP_WR   = 4'd4;
    localparam logic [3:0] S_PWR     = 4'd5;
    localparam logic [3:0] S_RMEND   = 4'd6;
    localparam logic [3:0] S_OUT_RD  = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_cursor, n_cursor;
    logic [CNT_W-1:0]    r_rd, n_rd;
    logic [CNT_W-1:0]    r_wr, n_wr;
    logic                r_sel, n_sel;
    logic                r_upd, n_upd;
    logic                r_rm, n_rm;
    logic [ID_WIDTH-1:0] r_id, n_id;
    logic                r_idv, n_idv;

    logic                r_out_valid, n_out_valid;
    logic [ID_WIDTH-1:0] r_out_ident;
    logic                r_out_cur, r_out_sel, r_out_upd, r_out_back, r_out_fwd;
    logic [CNT_W-1:0]    r_out_count;

    logic             has_cur, can_back, can_fwd;
    logic [CNT_W-1:0] lim, drop;
    logic             id_match;
    logic             load;
    logic             accept;

    assign has_cur  = (r_cursor != '0) && (r_cursor <= r_count);
    assign can_back = (r_cursor > ONE) && (r_cursor <= r_count);
    assign can_fwd  = (r_cursor != '0) && (r_cursor < r_count);

    // Effective limit and the number of oldest entries a push pushes out.
    assign lim  = (i_max_length < LIM_CAP) ? i_max_length : LIM_CAP;
    assign drop = (r_cursor >= lim) ? (r_cursor - lim + ONE) : '0;

    // The one comparator, shared by the repeat check and the remove scan.
    assign id_match = (i_mem_rd_data == r_id);

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign load        = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_cursor      = r_cursor;
        n_rd          = r_rd;
        n_wr          = r_wr;
        n_sel         = r_sel;
        n_upd         = r_upd;
        n_rm          = r_rm;
        n_id          = r_id;
        n_idv         = r_idv;
        o_mem_rd_en   = 1'b0;
        o_mem_rd_addr = AW'(r_rd);
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = AW'(r_wr);
        o_mem_wr_data = i_mem_rd_data;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_id    = i_req.ident;
                    n_idv   = i_req.ident_valid;
                    n_rm    = (i_req.req_type == REQ_REMOVE);
                    n_sel   = 1'b0;
                    n_upd   = 1'b0;
                    n_state = S_OUT_RD;
                    case (i_req.req_type)
                        REQ_PUSH: begin
                            if (i_req.ident_valid) begin
                                if (has_cur) begin
                                    n_state = S_PCHK_RD;
                                end else if (lim == '0) begin
                                    n_count  = '0;
                                    n_cursor = '0;
                                    n_upd    = 1'b1;
                                end else begin
                                    n_rd    = drop;
                                    n_wr    = '0;
                                    n_state = (drop < r_cursor) ? S_CP_RD : S_PWR;
                                end
                            end
                        end
                        REQ_BACK: begin
                            if (can_back) begin
                                n_cursor = r_cursor - ONE;
                                n_sel    = 1'b1;
                                n_upd    = 1'b1;
                            end
                        end
                        REQ_FORWARD: begin
                            if (can_fwd) begin
                                n_cursor = r_cursor + ONE;
                                n_sel    = 1'b1;
                                n_upd    = 1'b1;
                            end
                        end
                        REQ_REMOVE: begin
                            n_rd    = '0;
                            n_wr    = '0;
                            n_sel   = 1'b1;
                            n_upd   = 1'b1;
                            n_state = (r_count != '0) ? S_CP_RD : S_RMEND;
                        end
                        REQ_CLEAR: begin
                            n_upd    = (r_count != '0) || (r_cursor != '0);
                            n_count  = '0;
                            n_cursor = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PCHK_RD: begin
                o_mem_rd_en   = 1'b1;
                o_mem_rd_addr = AW'(r_cursor - ONE);
                n_state       = S_PCHK;
            end
            S_PCHK: begin
                if (id_match) begin
                    n_state = S_OUT_RD;
                end else if (lim == '0) begin
                    n_count  = '0;
                    n_cursor = '0;
                    n_upd    = 1'b1;
                    n_state  = S_OUT_RD;
                end else begin
                    n_rd    = drop;
                    n_wr    = '0;
                    n_state = (drop < r_cursor) ? S_CP_RD : S_PWR;
                end
            end
            S_CP_RD: begin
                o_mem_rd_en = 1'b1;
                n_state     = S_CP_WR;
            end
            S_CP_WR: begin
                n_rd = r_rd + ONE;
                if (r_rm) begin
                    if (r_idv && id_match) begin
                        // A removed entry below the cursor pulls the cursor back.
                        if (r_wr < r_cursor) begin
                            n_cursor = r_cursor - ONE;
                        end
                    end else begin
                        o_mem_wr_en = 1'b1;
                        n_wr        = r_wr + ONE;
                    end
                    n_state = (n_rd < r_count) ? S_CP_RD : S_RMEND;
                end else begin
                    o_mem_wr_en = 1'b1;
                    n_wr        = r_wr + ONE;
                    n_state     = (n_rd < r_cursor) ? S_CP_RD : S_PWR;
                end
            end
            S_PWR: begin
                o_mem_wr_en   = 1'b1;
                o_mem_wr_data = r_id;
                n_cursor      = r_wr + ONE;
                n_count       = r_wr + ONE;
                n_upd         = 1'b1;
                n_state       = S_OUT_RD;
            end
            S_RMEND: begin
                n_count  = r_wr;
                n_cursor = (r_cursor > r_wr) ? r_wr : r_cursor;
                n_state  = S_OUT_RD;
            end
            S_OUT_RD: begin
                o_mem_rd_en   = has_cur;
                o_mem_rd_addr = AW'(r_cursor - ONE);
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd  <= n_rd;
        r_wr  <= n_wr;
        r_sel <= n_sel;
        r_upd <= n_upd;
        r_rm  <= n_rm;
        r_id  <= n_id;
        r_idv <= n_idv;
        if (load) begin
            r_out_ident <= has_cur ? i_mem_rd_data : '0;
            r_out_cur   <= has_cur;
            r_out_sel   <= r_sel;
            r_out_upd   <= r_upd;
            r_out_back  <= can_back;
            r_out_fwd   <= can_fwd;
            r_out_count <= r_count;
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.current_ident     = r_out_ident;
    assign o_rsp.current_valid     = r_out_cur;
    assign o_rsp.selection_changed = r_out_sel;
    assign o_rsp.history_updated   = r_out_upd;
    assign o_rsp.back_available    = r_out_back;
    assign o_rsp.forward_available = r_out_fwd;
    assign o_rsp.entry_count       = r_out_count;

    `BNH_ASSERT(a_cursor_in_range, i_clk, i_rst_n, r_cursor <= r_count, "cursor beyond count")
    `BNH_ASSERT_NEVER(a_count_cap, i_clk, i_rst_n, r_count > LIM_CAP, "count above capacity")
    `BNH_ASSERT(a_copy_order, i_clk, i_rst_n, (r_state == S_CP_WR) |-> (r_wr <= r_rd), "write ahead of read")
    `BNH_ASSERT(a_busy_after_accept, i_clk, i_rst_n, accept |=> !i_req.ready, "ready after accept")
    `BNH_ASSERT(a_load_shows, i_clk, i_rst_n, load |=> r_out_valid, "result not shown")

endmodule

FILE: hdl/bounded_navigation_history.sv
// Top level of the bounded back/forward navigation history.
//
//   channel  dir  handshake             content
//   i_req    in   valid/ready           req_type, ident, ident_valid
//   o_rsp    out  valid/ready           current selection, flags, entry_count
//   cfg      in   i_cfg_we, no ready    max_length (5 bits)
//
// One request is worked at a time; i_req.ready is high only while the sequencer idles.
// Back, forward, clear, unknown codes and invalid pushes go from idle straight to the
// result read. A valid push first reads the current entry, if there is one, for the
// repeat check; a repeat ends there, a zero limit clears the history, and otherwise the
// kept entries are copied down and the new one written. A remove scans every entry
// through the one memory read port. A result waiting in the output register does not
// stall the next request until that request is ready to show its own result.
// Reset is synchronous, active low; the entry memory is not cleared.
module bounded_navigation_history
    import bnh_pkg::*;
#(
    parameter int DEPTH    = BNH_DEPTH,
    parameter int ID_WIDTH = BNH_ID_WIDTH,
    localparam int AW      = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    bnh_req_if.sink          i_req,
    bnh_rsp_if.source        o_rsp
);

    logic [CNT_W-1:0]    r_max_length;
    logic                mem_rd_en;
    logic [AW-1:0]       mem_rd_addr;
    logic [ID_WIDTH-1:0] mem_rd_data;
    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    logic [ID_WIDTH-1:0] mem_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RESET;
        end else if (i_cfg_we) begin
            r_max_length <= i_cfg_wdata;
        end
    end

    bnh_ctrl #(
        .DEPTH    (DEPTH),
        .ID_WIDTH (ID_WIDTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_length  (r_max_length),
        .i_req         (i_req),
        .o_rsp         (o_rsp),
        .o_mem_rd_en   (mem_rd_en),
        .o_mem_rd_addr (mem_rd_addr),
        .i_mem_rd_data (mem_rd_data),
        .o_mem_wr_en   (mem_wr_en),
        .o_mem_wr_addr (mem_wr_addr),
        .o_mem_wr_data (mem_wr_data)
    );

    bnh_store #(
        .DEPTH    (DEPTH),
        .ID_WIDTH (ID_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

endmodule
